// ===== hdl/lof_pkg.sv =====
// Shared types and constants of the 3x3 Laplacian outline filter.
package lof_pkg;

  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int ROW_W      = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 3;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COLOUR_MODE  = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;
  localparam logic [CHAN_W-1:0] CHAN_MIN = 8'h00;

  typedef logic [PIX_W-1:0] pixel_t;

  // One channel of the 3x3 neighbourhood, indexed [row][column], row 0 on top.
  typedef logic [2:0][2:0][CHAN_W-1:0] chan_win_t;

  // Which frame borders the centre pixel touches.
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

endpackage

// ===== hdl/lof_line_store.sv =====
// Upper and middle line stores with registered reads and write forwarding.
module lof_line_store import lof_pkg::*; #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pixel_t        wr_upper,
  input  pixel_t        wr_middle,
  output pixel_t        rd_upper,
  output pixel_t        rd_middle
);

  pixel_t mem_upper [DEPTH];
  pixel_t mem_middle [DEPTH];
  pixel_t ram_upper;
  pixel_t ram_middle;
  pixel_t fwd_upper;
  pixel_t fwd_middle;
  logic   fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_upper[wr_addr]  <= wr_upper;
      mem_middle[wr_addr] <= wr_middle;
    end
    if (rd_en) begin
      ram_upper  <= mem_upper[rd_addr];
      ram_middle <= mem_middle[rd_addr];
      fwd_upper  <= wr_upper;
      fwd_middle <= wr_middle;
    end
  end

  // A read that meets a write to the same entry in the same cycle sees the old
  // contents, so the written words are kept and returned instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_upper  = fwd_hit ? fwd_upper : ram_upper;
  assign rd_middle = fwd_hit ? fwd_middle : ram_middle;

endmodule

// ===== hdl/lof_kernel.sv =====
// One channel of the 3x3 Laplacian kernel with border replication and clamping.
module lof_kernel import lof_pkg::*; (
  input  chan_win_t         win,
  input  border_t           border,
  output logic [CHAN_W-1:0] result
);

  logic [1:0]         row_sel [3];
  logic [1:0]         col_sel [3];
  logic [11:0]        nsum;
  logic [11:0]        centre9;
  logic signed [12:0] diff;

  always_comb begin
    row_sel[0] = border.top    ? 2'd1 : 2'd0;
    row_sel[1] = 2'd1;
    row_sel[2] = border.bottom ? 2'd1 : 2'd2;
    col_sel[0] = border.left   ? 2'd1 : 2'd0;
    col_sel[1] = 2'd1;
    col_sel[2] = border.right  ? 2'd1 : 2'd2;
  end

  // Sum of the nine taps after replication; the centre is among them, so the
  // centre weight of eight becomes nine here.
  always_comb begin
    nsum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        nsum = nsum + 12'(win[row_sel[i]][col_sel[j]]);
      end
    end
  end

  assign centre9 = (12'(win[1][1]) << 3) + 12'(win[1][1]);
  assign diff    = $signed({1'b0, centre9}) - $signed({1'b0, nsum});

  always_comb begin
    if (diff < 0) begin
      result = CHAN_MIN;
    end else if (diff > $signed(13'(CHAN_MAX))) begin
      result = CHAN_MAX;
    end else begin
      result = diff[CHAN_W-1:0];
    end
  end

endmodule

// ===== hdl/laplacian_outline_filter_3x3_top.sv =====
// Top level of the 3x3 Laplacian outline filter: registers, line stores, window and output.
//
// The block takes one request per clock on the pixel channel while pix_stall is low and
// filters each pixel with eight times the centre minus its eight neighbours, clamped to
// 0..255, per colour channel when colour_mode is set (else green and blue are zero), with
// the frame's edge pixels replicated across the borders. A request starts the line store
// read when it is accepted, its column joins the 3x3 window as it leaves stage 1, and the
// kernel result of stage 2 is registered at the output. Results lag their centre pixel by
// one row plus one pixel; after the last pixel of a frame, width plus one drain requests
// push out the remaining results, the last one carrying frame_end. The sustained rate while
// pix_stall is low is one request per clock, set by the single read and single write
// port of the line store memory, which sees one read-modify-write per request. A two-entry
// output stage (output register plus skid register) lets the pixel channel keep accepting
// while a result waits, and pix_stall rises only when both entries are full. The line
// stores need no clearing pass after reset. Register writes restart the frame and must be
// made only while no request is in flight.
module laplacian_outline_filter_3x3_top import lof_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  // pixel channel
  input  logic                pix_valid,
  output logic                pix_stall,
  input  logic                cmd,
  input  logic [CHAN_W-1:0]   chan_red,
  input  logic [CHAN_W-1:0]   chan_green,
  input  logic [CHAN_W-1:0]   chan_blue,
  // result channel
  output logic                res_valid,
  input  logic                res_stall,
  output logic [CHAN_W-1:0]   res_red,
  output logic [CHAN_W-1:0]   res_green,
  output logic [CHAN_W-1:0]   res_blue,
  output logic                frame_end
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);

  // Configuration registers hold the values as written; the geometry used by the
  // datapath is the clamped copy below.
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic            colour_mode;
  logic            cfg_write;

  logic [WW-1:0]    eff_w;
  logic [ROW_W-1:0] eff_h;
  logic [31:0]      fw32;

  // Raster position of the next accepted request.
  logic [COL_W-1:0] in_column;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_column_next;
  logic [ROW_W-1:0] in_row_next;

  logic             adv;
  logic             accept;
  logic             draining;
  logic             take;
  logic [WW-1:0]    col_inc;
  logic             has_out;
  logic             is_last;
  border_t          border_in;
  pixel_t           pix_in;

  // Stage 1: line store read in flight.
  logic             s1_valid;
  logic             s1_out;
  logic             s1_last;
  border_t          s1_border;
  pixel_t           s1_pix;
  logic [COL_W-1:0] s1_addr;

  // Stage 2: the window holds this request's neighbourhood.
  logic             s2_valid;
  logic             s2_out;
  logic             s2_last;
  border_t          s2_border;

  pixel_t           ls_upper;
  pixel_t           ls_middle;
  pixel_t           win [3][3];
  chan_win_t        chan_win [3];
  logic [CHAN_W-1:0] kern_res [3];

  logic              p_valid;
  logic [CHAN_W-1:0] p_green;
  logic [CHAN_W-1:0] p_blue;

  logic              skid_valid;
  logic [CHAN_W-1:0] skid_red;
  logic [CHAN_W-1:0] skid_green;
  logic [CHAN_W-1:0] skid_blue;
  logic              skid_last;

  // ---------------------------------------------------------------------------
  // Configuration port. Every access completes in its access cycle.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_W'(MIN_DIM);
      frame_height <= FH_W'(MIN_DIM);
      colour_mode  <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_FRAME_WIDTH:  frame_width  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[FH_W-1:0];
        REG_COLOUR_MODE:  colour_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height);
      REG_COLOUR_MODE:  prdata = PDATA_W'(colour_mode);
      default:          prdata = '0;
    endcase
  end

  // Out-of-range geometry is pulled into the supported range.
  assign fw32 = 32'(frame_width);

  always_comb begin
    if (fw32 < 32'(MIN_DIM)) begin
      eff_w = WW'(MIN_DIM);
    end else if (fw32 > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(fw32);
    end
    if (frame_height < FH_W'(MIN_DIM)) begin
      eff_h = ROW_W'(MIN_DIM);
    end else if (frame_height > FH_W'(MAX_HEIGHT)) begin
      eff_h = ROW_W'(MAX_HEIGHT);
    end else begin
      eff_h = ROW_W'(frame_height);
    end
  end

  // ---------------------------------------------------------------------------
  // Request intake and raster position. The whole pipeline moves whenever the
  // skid register is free, so the stall seen by the source is a register.
  // ---------------------------------------------------------------------------
  assign adv       = !skid_valid;
  assign pix_stall = skid_valid;
  assign accept    = pix_valid && adv;

  // Past the last row every request, pixel or drain, counts as a drain. A drain
  // before that point is dropped without touching any state.
  assign draining = in_row >= eff_h;
  assign take     = accept && (draining || (cmd == CMD_PIXEL));
  assign pix_in   = draining ? '0 : {chan_red, chan_green, chan_blue};
  assign col_inc  = WW'(in_column) + WW'(1);

  // The request completes the neighbourhood of the pixel one row and one column
  // back. At column zero that centre is the last pixel of the row two rows up.
  always_comb begin
    if (in_column == '0) begin
      has_out          = in_row >= ROW_W'(2);
      border_in.top    = in_row == ROW_W'(2);
      border_in.bottom = in_row == eff_h + ROW_W'(1);
      border_in.left   = 1'b0;
      border_in.right  = 1'b1;
    end else begin
      has_out          = in_row >= ROW_W'(1);
      border_in.top    = in_row == ROW_W'(1);
      border_in.bottom = in_row == eff_h;
      border_in.left   = in_column == COL_W'(1);
      border_in.right  = 1'b0;
    end
    is_last = has_out && border_in.bottom && border_in.right;

    if (is_last) begin
      in_column_next = '0;
      in_row_next    = '0;
    end else if (col_inc >= eff_w) begin
      in_column_next = '0;
      in_row_next    = in_row + ROW_W'(1);
    end else begin
      in_column_next = col_inc[COL_W-1:0];
      in_row_next    = in_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      in_column <= '0;
      in_row    <= '0;
    end else if (take) begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores: the column read returns the two rows above; the middle row
  // moves up and the new pixel becomes the middle row.
  // ---------------------------------------------------------------------------
  lof_line_store #(
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (take),
    .rd_addr  (in_column),
    .wr_en    (adv && s1_valid),
    .wr_addr  (s1_addr),
    .wr_upper (ls_middle),
    .wr_middle(s1_pix),
    .rd_upper (ls_upper),
    .rd_middle(ls_middle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= take;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (take) begin
        s1_out    <= has_out;
        s1_last   <= is_last;
        s1_border <= border_in;
        s1_pix    <= pix_in;
        s1_addr   <= in_column;
      end
      s2_out    <= s1_out;
      s2_last   <= s1_last;
      s2_border <= s1_border;
    end
  end

  // The window shifts left by one column for every request taken, drains included.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (adv && s1_valid) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= ls_upper;
      win[1][2] <= ls_middle;
      win[2][2] <= s1_pix;
    end
  end

  // ---------------------------------------------------------------------------
  // Kernel, one instance per colour channel; red sits in the top byte.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          chan_win[ch][i][j] = win[i][j][(2 - ch) * CHAN_W +: CHAN_W];
        end
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    lof_kernel u_kernel (
      .win   (chan_win[ch]),
      .border(s2_border),
      .result(kern_res[ch])
    );
  end

  assign p_valid = adv && s2_valid && s2_out;
  assign p_green = colour_mode ? kern_res[1] : CHAN_MIN;
  assign p_blue  = colour_mode ? kern_res[2] : CHAN_MIN;

  // ---------------------------------------------------------------------------
  // Output register with a skid register behind it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= p_valid;
      end
    end else if (p_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || !res_stall) begin
      if (skid_valid) begin
        res_red   <= skid_red;
        res_green <= skid_green;
        res_blue  <= skid_blue;
        frame_end <= skid_last;
      end else if (p_valid) begin
        res_red   <= kern_res[0];
        res_green <= p_green;
        res_blue  <= p_blue;
        frame_end <= s2_last;
      end
    end
    if (res_valid && res_stall && p_valid) begin
      skid_red   <= kern_res[0];
      skid_green <= p_green;
      skid_blue  <= p_blue;
      skid_last  <= s2_last;
    end
  end

endmodule
